// File: sv/motor_speed_cruise_controller_defines.svh
// assertion macros for the motor speed cruise controller
`ifndef MOTOR_SPEED_CRUISE_CONTROLLER_DEFINES_SVH
`define MOTOR_SPEED_CRUISE_CONTROLLER_DEFINES_SVH

`ifndef NO_ASSERTIONS

// condition that must hold at every clock edge outside reset
`define MSC_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("controller check failed");

// condition that must hold in the cycle after the trigger
`define MSC_ASSERT_NEXT(lbl, trig, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("controller sequence check failed");

`else

`define MSC_ASSERT(lbl, cond)
`define MSC_ASSERT_NEXT(lbl, trig, cons)

`endif

`endif

// File: sv/msc_pkg.sv
// shared types, widths and command codes of the motor speed cruise controller
`default_nettype none

package msc_pkg;

    // default scaling
    localparam int PWM_FULL_SCALE_DEF   = 1500;
    localparam int SPEED_FULL_SCALE_DEF = 48;

    // field widths
    localparam int SP_W     = 12;
    localparam int MAG_W    = 11;
    localparam int DUTY_W   = 11;
    localparam int DIST_W   = 12;
    localparam int CMD_W    = 8;
    localparam int SPEED_W  = 8;
    localparam int WIN_W    = 7;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 32;
    localparam int IN_DW    = 24;
    localparam int OUT_DW   = 24;

    // setpoint limits and steps
    localparam int SETPOINT_LIMIT = 2000;
    localparam logic signed [SP_W-1:0] STEP_COARSE = 12'sd50;
    localparam logic signed [SP_W-1:0] STEP_FINE   = 12'sd10;

    // adaptive windows
    localparam logic [WIN_W-1:0] WIN_CLOSE_LO = 7'd30;
    localparam logic [WIN_W-1:0] WIN_CLOSE_HI = 7'd60;
    localparam logic [WIN_W-1:0] WIN_MID_LO   = 7'd60;
    localparam logic [WIN_W-1:0] WIN_MID_HI   = 7'd90;
    localparam logic [WIN_W-1:0] WIN_LONG_LO  = 7'd90;
    localparam logic [WIN_W-1:0] WIN_LONG_HI  = 7'd120;

    // danger distance after reset
    localparam logic [DIST_W-1:0] DANGER_RESET = 12'd20;

    // register index of the danger distance
    localparam logic REG_DANGER = 1'b0;

    // ascii command characters; anything else, the idle byte included, is a slow-down
    localparam logic [CMD_W-1:0] CMD_ACCEL       = 8'h41;
    localparam logic [CMD_W-1:0] CMD_DECEL       = 8'h44;
    localparam logic [CMD_W-1:0] CMD_STOP        = 8'h53;
    localparam logic [CMD_W-1:0] CMD_MODE_OFF    = 8'h4F;
    localparam logic [CMD_W-1:0] CMD_MODE_STATIC = 8'h4E;
    localparam logic [CMD_W-1:0] CMD_MODE_ADAPT  = 8'h56;
    localparam logic [CMD_W-1:0] CMD_WIN_CLOSE   = 8'h43;
    localparam logic [CMD_W-1:0] CMD_WIN_MID     = 8'h4D;
    localparam logic [CMD_W-1:0] CMD_WIN_LONG    = 8'h4C;

    typedef enum logic [1:0] {
        MODE_OFF    = 2'd0,
        MODE_STATIC = 2'd1,
        MODE_ADAPT  = 2'd2
    } mode_t;

    typedef enum logic {
        KIND_CMD  = 1'b0,
        KIND_TICK = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t             kind;
        logic [CMD_W-1:0]  cmd;
        logic [DIST_W-1:0] obs_dist;
    } item_t;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              motor_on;
        logic              alarm;
        mode_t             mode;
    } status_t;

endpackage

`default_nettype wire

// File: sv/msc_cfg.sv
// configuration register block holding the danger distance
`default_nettype none

module msc_cfg
    import msc_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [CFG_DW-1:0] pwdata,
    output logic      [CFG_DW-1:0] prdata,
    output logic                   pready,
    output logic      [DIST_W-1:0] guard_dist
);

    logic              sel_danger;
    logic              wr_en;
    logic [DIST_W-1:0] danger_reg;

    // address decode, one register, selected whenever the top address bit is zero
    assign sel_danger = (paddr[CFG_AW-1] == REG_DANGER);
    assign wr_en      = psel && penable && pwrite;
    assign pready     = 1'b1;

    // danger distance register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            danger_reg <= DANGER_RESET;
        end
        else if (wr_en && sel_danger)
        begin
            danger_reg <= pwdata[DIST_W-1:0];
        end
    end

    // read back
    assign prdata     = sel_danger ? CFG_DW'(danger_reg) : '0;
    assign guard_dist = danger_reg;

endmodule

`default_nettype wire

// File: sv/msc_core.sv
// setpoint, mode and window state with the per-request update
`default_nettype none

module msc_core
    import msc_pkg::*;
#(
    parameter int PWM_FULL_SCALE = PWM_FULL_SCALE_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              adv,
    input  wire logic              in_valid,
    input  wire item_t             item,
    input  wire logic [DIST_W-1:0] guard_dist,
    output status_t                status,
    output logic                   sp_neg,
    output logic      [MAG_W-1:0]  sp_mag
);

    localparam logic signed [SP_W-1:0] FULL_S = SP_W'(PWM_FULL_SCALE);
    localparam logic signed [SP_W:0]   SUM_HI = (SP_W+1)'(SETPOINT_LIMIT);
    localparam logic signed [SP_W:0]   SUM_LO = -((SP_W+1)'(SETPOINT_LIMIT));

    logic signed [SP_W-1:0] sp_reg;
    mode_t                  mode_reg;
    logic [WIN_W-1:0]       win_hi_reg;
    logic [WIN_W-1:0]       win_lo_reg;
    logic [DUTY_W-1:0]      duty_reg;
    logic                   motor_reg;
    logic                   alarm_reg;

    logic signed [SP_W-1:0] sp_next;
    mode_t                  mode_next;
    logic [WIN_W-1:0]       win_hi_next;
    logic [WIN_W-1:0]       win_lo_next;
    logic [DUTY_W-1:0]      duty_next;
    logic                   motor_next;
    logic                   alarm_next;

    logic                   in_scale;
    logic                   danger_hit;
    logic                   nudge_en;
    logic                   sp_clear;
    logic signed [SP_W-1:0] delta;
    logic signed [SP_W:0]   sum;
    logic signed [SP_W-1:0] sp_nudged;
    logic [SP_W-1:0]        sp_abs;

    status_t                status_reg;
    logic                   neg_reg;
    logic [MAG_W-1:0]       mag_reg;

    assign in_scale   = !sp_reg[SP_W-1] && (sp_reg <= FULL_S);
    assign danger_hit = (item.obs_dist <= guard_dist);

    // decode of command or tick into a setpoint step and mode/window loads
    always_comb
    begin
        nudge_en    = 1'b0;
        sp_clear    = 1'b0;
        delta       = '0;
        mode_next   = mode_reg;
        win_hi_next = win_hi_reg;
        win_lo_next = win_lo_reg;
        if (item.kind == KIND_CMD)
        begin
            unique case (item.cmd)
                CMD_ACCEL:
                begin
                    nudge_en = in_scale && (mode_reg == MODE_OFF);
                    delta    = STEP_COARSE;
                end
                CMD_DECEL:
                begin
                    nudge_en = in_scale;
                    delta    = -STEP_COARSE;
                end
                CMD_STOP:        sp_clear  = 1'b1;
                CMD_MODE_OFF:    mode_next = MODE_OFF;
                CMD_MODE_STATIC: mode_next = MODE_STATIC;
                CMD_MODE_ADAPT:  mode_next = MODE_ADAPT;
                CMD_WIN_CLOSE:
                begin
                    win_hi_next = WIN_CLOSE_HI;
                    win_lo_next = WIN_CLOSE_LO;
                end
                CMD_WIN_MID:
                begin
                    win_hi_next = WIN_MID_HI;
                    win_lo_next = WIN_MID_LO;
                end
                CMD_WIN_LONG:
                begin
                    win_hi_next = WIN_LONG_HI;
                    win_lo_next = WIN_LONG_LO;
                end
                default:
                begin
                    nudge_en = (mode_reg == MODE_OFF);
                    delta    = -STEP_FINE;
                end
            endcase
        end
        else if (mode_reg == MODE_ADAPT)
        begin
            // adaptive rule: speed up beyond the window, back off at or below its lower edge unless in danger
            if (item.obs_dist > DIST_W'(win_hi_reg))
            begin
                nudge_en = 1'b1;
                delta    = STEP_FINE;
            end
            else if ((item.obs_dist <= DIST_W'(win_lo_reg)) && !danger_hit)
            begin
                nudge_en = 1'b1;
                delta    = -STEP_FINE;
            end
        end
    end

    // saturating step of the setpoint
    always_comb
    begin
        sum = {sp_reg[SP_W-1], sp_reg} + {delta[SP_W-1], delta};
        if (!nudge_en)
        begin
            sp_nudged = sp_reg;
        end
        else if (sum > SUM_HI)
        begin
            sp_nudged = SP_W'(SUM_HI);
        end
        else if (sum < SUM_LO)
        begin
            sp_nudged = SP_W'(SUM_LO);
        end
        else
        begin
            sp_nudged = sum[SP_W-1:0];
        end
    end

    // stop command clears the setpoint; tick output: stop on danger, else clamp and drive
    always_comb
    begin
        sp_next    = sp_nudged;
        duty_next  = duty_reg;
        motor_next = motor_reg;
        alarm_next = alarm_reg;
        if (sp_clear)
        begin
            sp_next = '0;
        end
        else if (item.kind == KIND_TICK)
        begin
            if (danger_hit)
            begin
                motor_next = 1'b0;
                alarm_next = 1'b1;
            end
            else
            begin
                motor_next = 1'b1;
                alarm_next = 1'b0;
                if (sp_nudged > FULL_S)
                begin
                    sp_next = FULL_S;
                end
                else if (sp_nudged[SP_W-1])
                begin
                    sp_next = '0;
                end
                duty_next = sp_next[DUTY_W-1:0];
            end
        end
    end

    assign sp_abs = sp_next[SP_W-1] ? (~sp_next + 1'b1) : sp_next;

    // controller state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sp_reg     <= '0;
            mode_reg   <= MODE_OFF;
            win_hi_reg <= '0;
            win_lo_reg <= '0;
            duty_reg   <= '0;
            motor_reg  <= 1'b0;
            alarm_reg  <= 1'b0;
        end
        else if (adv && in_valid)
        begin
            sp_reg     <= sp_next;
            mode_reg   <= mode_next;
            win_hi_reg <= win_hi_next;
            win_lo_reg <= win_lo_next;
            duty_reg   <= duty_next;
            motor_reg  <= motor_next;
            alarm_reg  <= alarm_next;
        end
    end

    // status stage towards the speed estimate
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            status_reg <= '{duty: duty_next, motor_on: motor_next,
                            alarm: alarm_next, mode: mode_next};
            neg_reg    <= sp_next[SP_W-1];
            mag_reg    <= sp_abs[MAG_W-1:0];
        end
    end

    assign status = status_reg;
    assign sp_neg = neg_reg;
    assign sp_mag = mag_reg;

endmodule

`default_nettype wire

// File: sv/msc_speed.sv
// speed estimate: setpoint times speed scale over pwm scale, toward zero
`default_nettype none

module msc_speed
    import msc_pkg::*;
#(
    parameter int PWM_FULL_SCALE   = PWM_FULL_SCALE_DEF,
    parameter int SPEED_FULL_SCALE = SPEED_FULL_SCALE_DEF
)
(
    input  wire logic               clk,
    input  wire logic               adv,
    input  wire status_t            status_in,
    input  wire logic               sp_neg,
    input  wire logic [MAG_W-1:0]   sp_mag,
    output status_t                 status_out,
    output logic      [SPEED_W-1:0] speed
);

    // reciprocal of the pwm scale, exact for every scaled magnitude
    localparam int K_W   = $clog2(SPEED_FULL_SCALE + 1);
    localparam int M_W   = MAG_W + K_W;
    localparam int P_W   = $clog2(PWM_FULL_SCALE + 1);
    localparam int SHIFT = M_W + P_W;
    localparam int R_W   = M_W + 2;
    localparam int PR_W  = M_W + R_W;
    localparam int Q_W   = PR_W - SHIFT;
    localparam logic [63:0] RECIP_WIDE =
        ((64'd1 << SHIFT) + 64'(PWM_FULL_SCALE) - 64'd1) / 64'(PWM_FULL_SCALE);
    localparam logic [R_W-1:0] RECIP = RECIP_WIDE[R_W-1:0];
    localparam logic [K_W-1:0] SCALE = K_W'(SPEED_FULL_SCALE);

    logic [M_W-1:0]     scaled_reg;
    logic               neg_reg;
    status_t            status_mid_reg;
    logic [PR_W-1:0]    prod;
    logic [Q_W-1:0]     quot;
    logic [SPEED_W-1:0] quot_low;
    logic [SPEED_W-1:0] speed_next;
    status_t            status_out_reg;
    logic [SPEED_W-1:0] speed_reg;

    // first stage: scale the magnitude
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            scaled_reg     <= M_W'(sp_mag) * M_W'(SCALE);
            neg_reg        <= sp_neg;
            status_mid_reg <= status_in;
        end
    end

    // second stage: divide by reciprocal multiply, restore the sign
    assign prod       = PR_W'(scaled_reg) * PR_W'(RECIP);
    assign quot       = prod[PR_W-1:SHIFT];
    assign quot_low   = SPEED_W'(quot);
    assign speed_next = neg_reg ? (~quot_low + 1'b1) : quot_low;

    // result register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            status_out_reg <= status_mid_reg;
            speed_reg      <= speed_next;
        end
    end

    assign status_out = status_out_reg;
    assign speed      = speed_reg;

endmodule

`default_nettype wire

// File: sv/motor_speed_cruise_controller.sv
// Motor speed cruise controller. Each request on the slave stream is either a command
// byte (tuser low) or a control tick carrying a measured distance (tuser high), and
// gives exactly one status on the master stream. One request is taken every clock while
// the master side does not stall; a status appears once its request has passed the input
// register, the state update, the scaling multiply of the speed estimate and the
// reciprocal multiply into the output register. A stall on the master side holds the
// whole pipeline. After reset the setpoint, mode, windows, duty, motor and alarm are
// all zero and the danger distance is 20; the user is to write it over the register port
// only while the stream is idle, which the block itself does not enforce.
`default_nettype none

`include "motor_speed_cruise_controller_defines.svh"

module motor_speed_cruise_controller
    import msc_pkg::*;
#(
    parameter int PWM_FULL_SCALE   = PWM_FULL_SCALE_DEF,
    parameter int SPEED_FULL_SCALE = SPEED_FULL_SCALE_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    // register port
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [CFG_AW-1:0] paddr,
    input  wire logic [CFG_DW-1:0] pwdata,
    output logic      [CFG_DW-1:0] prdata,
    output logic                   pready,
    // request stream
    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [IN_DW-1:0]  s_axis_tdata,   // command_byte[7:0], distance[19:8]
    input  wire logic              s_axis_tuser,   // kind[0]
    // status stream
    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic      [OUT_DW-1:0] m_axis_tdata    // duty[10:0], motor_on[11], alarm[12],
                                                   // speed_estimate[20:13], cruise_mode[22:21]
);

    logic              adv;
    logic              in_valid_reg;
    logic              s1_valid_reg;
    logic              s2_valid_reg;
    logic              out_valid_reg;
    item_t             item_reg;
    logic [DIST_W-1:0] guard_dist;
    status_t           core_status;
    logic              sp_neg;
    logic [MAG_W-1:0]  sp_mag;
    status_t           out_status;
    logic [SPEED_W-1:0] out_speed;

    // register port
    msc_cfg u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .guard_dist (guard_dist)
    );

    // whole pipeline moves unless the output register is full and stalled
    assign adv           = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = adv;

    // pipeline valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            in_valid_reg  <= s_axis_tvalid;
            s1_valid_reg  <= in_valid_reg;
            s2_valid_reg  <= s1_valid_reg;
            out_valid_reg <= s2_valid_reg;
        end
    end

    // input register
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            item_reg <= '{kind:     kind_t'(s_axis_tuser),
                          cmd:      s_axis_tdata[CMD_W-1:0],
                          obs_dist: s_axis_tdata[CMD_W+DIST_W-1:CMD_W]};
        end
    end

    // state update
    msc_core #(
        .PWM_FULL_SCALE (PWM_FULL_SCALE)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .adv        (adv),
        .in_valid   (in_valid_reg),
        .item       (item_reg),
        .guard_dist (guard_dist),
        .status     (core_status),
        .sp_neg     (sp_neg),
        .sp_mag     (sp_mag)
    );

    // speed estimate and result register
    msc_speed #(
        .PWM_FULL_SCALE   (PWM_FULL_SCALE),
        .SPEED_FULL_SCALE (SPEED_FULL_SCALE)
    ) u_speed (
        .clk        (clk),
        .adv        (adv),
        .status_in  (core_status),
        .sp_neg     (sp_neg),
        .sp_mag     (sp_mag),
        .status_out (out_status),
        .speed      (out_speed)
    );

    // status packing
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_status.mode, out_speed, out_status.alarm,
                            out_status.motor_on, out_status.duty};

    // checks
    `MSC_ASSERT(a_run_alarm_excl, !(out_valid_reg && out_status.motor_on && out_status.alarm))
    `MSC_ASSERT(a_duty_range, !out_valid_reg || (out_status.duty <= DUTY_W'(PWM_FULL_SCALE)))
    `MSC_ASSERT_NEXT(a_accept_loads, s_axis_tvalid && s_axis_tready, in_valid_reg)
    `MSC_ASSERT_NEXT(a_result_reaches_out, s2_valid_reg && adv, out_valid_reg)

endmodule

`default_nettype wire
